// File: hw/rtl/hhlp_pkg.sv
package hhlp_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int NAME_LEN = 14;
  localparam int NAME_POS_W = 4;

  localparam logic [LENGTH_BITS-1:0] MAX_BODY_RESET = LENGTH_BITS'(1000000);

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] EV_STATUS_END = 2'd0;
  localparam logic [1:0] EV_HEADER_END = 2'd1;
  localparam logic [1:0] EV_HEADERS_DONE = 2'd2;
  localparam logic [1:0] EV_BODY_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   content_length;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } result_t;

  function automatic logic [7:0] target_char(input logic [NAME_POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:  c = 8'h43; // C
      4'd1:  c = 8'h6f; // o
      4'd2:  c = 8'h6e; // n
      4'd3:  c = 8'h74; // t
      4'd4:  c = 8'h65; // e
      4'd5:  c = 8'h6e; // n
      4'd6:  c = 8'h74; // t
      4'd7:  c = 8'h2d; // -
      4'd8:  c = 8'h4c; // L
      4'd9:  c = 8'h65; // e
      4'd10: c = 8'h6e; // n
      4'd11: c = 8'h67; // g
      4'd12: c = 8'h74; // t
      4'd13: c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/http_header_length_parser.sv
// http response header parser with content-length extraction
//
// input channel: one response byte per word on data_byte, in_valid / in_stall.
// output channel: event words (event_kind, is_content_length, body_length, last)
// on out_valid / out_stall. a byte gives zero, one or two event words; last
// marks the final word of a byte.
// config: cfg_we writes cfg_data into max_body, the default body length and
// the cap for parsed lengths. write it only while no byte is in flight.
//
// path: a byte accepted is registered in byte_q and scanned there; its event
// words are written into the result queue and shown from its head.
// throughput: one byte per cycle while the queue has room; the line and
// value scan is combinational; a four-word result queue sits before the output.
// the input stalls only while that queue has fewer than two free slots.
// reset: synchronous; clears the scan back to the status line, empties the
// queue and restores max_body to 1000000.
// when the receiver stalls, the queued word holds and the queue fills; after
// that the input stall rises and no byte is dropped.
module http_header_length_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             cfg_we,
  input  logic [hhlp_pkg::LENGTH_BITS-1:0] cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       event_kind,
  output logic                             is_content_length,
  output logic [hhlp_pkg::LENGTH_BITS-1:0] body_length,
  output logic                             last
);
  import hhlp_pkg::*;

  logic [LENGTH_BITS-1:0] max_body;
  logic                   byte_valid;
  logic [7:0]             byte_q;
  logic                   room_for_two;
  logic                   fire;
  logic [1:0]             res_count;
  logic [1:0]             push_count;
  result_t                res0, res1, head;

  assign fire       = byte_valid && room_for_two;
  assign in_stall   = byte_valid && !room_for_two;
  assign push_count = fire ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body <= MAX_BODY_RESET;
    end else if (cfg_we) begin
      max_body <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
    end
  end

  hhlp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (byte_q),
    .max_body  (max_body),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  hhlp_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push0        (res0),
    .push1        (res1),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .head         (head)
  );

  assign event_kind        = head.kind;
  assign is_content_length = head.content_length;
  assign body_length       = head.length;
  assign last              = head.last;

endmodule

// File: hw/rtl/hhlp_scan.sv
module hhlp_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [7:0]                      data_byte,
  input  logic [hhlp_pkg::LENGTH_BITS-1:0] max_body,
  output logic [1:0]                      res_count,
  output hhlp_pkg::result_t               res0,
  output hhlp_pkg::result_t               res1
);
  import hhlp_pkg::*;

  typedef enum logic [1:0] {
    PH_STATUS, PH_HEADER, PH_BODY, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    VP_SKIP, VP_SIGN, VP_DIGITS, VP_STOP
  } value_phase_t;

  localparam int ACC_W = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [NAME_POS_W-1:0] NAME_END = NAME_POS_W'(NAME_LEN);

  phase_t                  phase, phase_next;
  logic                    prev_was_cr, prev_was_cr_next;
  logic                    line_first_byte, line_first_byte_next;
  logic                    name_empty, name_empty_next;
  logic                    colon_seen, colon_seen_next;
  logic [NAME_POS_W-1:0]   name_match_pos, name_match_pos_next;
  logic                    name_still_matches, name_still_matches_next;
  value_phase_t            value_phase, value_phase_next;
  logic                    value_negative, value_negative_next;
  logic [LENGTH_BITS-1:0]  value_acc, value_acc_next;
  logic                    length_found, length_found_next;
  logic [LENGTH_BITS-1:0]  length_value, length_value_next;
  logic [LENGTH_BITS-1:0]  body_count, body_count_next;

  logic [LENGTH_BITS-1:0]  cur_len;
  logic [LENGTH_BITS-1:0]  body_inc;
  logic [ACC_W-1:0]        acc_times_ten;
  logic                    is_digit;
  logic                    is_ws;
  logic                    line_end;
  logic                    match;

  assign cur_len  = length_found ? length_value : max_body;
  assign body_inc = (body_count != LEN_MAX) ? body_count + 1'b1 : body_count;
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_ws    = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
  assign line_end = prev_was_cr && (data_byte == CH_LF);
  assign match    = colon_seen && name_still_matches && (name_match_pos == NAME_END);
  assign acc_times_ten = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1)
                       + ACC_W'(data_byte - CH_ZERO);

  always_comb begin
    phase_next              = phase;
    prev_was_cr_next        = prev_was_cr;
    line_first_byte_next    = line_first_byte;
    name_empty_next         = name_empty;
    colon_seen_next         = colon_seen;
    name_match_pos_next     = name_match_pos;
    name_still_matches_next = name_still_matches;
    value_phase_next        = value_phase;
    value_negative_next     = value_negative;
    value_acc_next          = value_acc;
    length_found_next       = length_found;
    length_value_next       = length_value;
    body_count_next         = body_count;
    res_count               = 2'd0;
    res0 = '{kind: EV_STATUS_END, content_length: 1'b0, length: cur_len, last: 1'b1};
    res1 = '{kind: EV_BODY_DONE, content_length: 1'b0, length: cur_len, last: 1'b1};

    if (phase == PH_DONE) begin
      res_count = 2'd0;
    end else if (phase == PH_BODY) begin
      body_count_next = body_inc;
      if (body_inc >= cur_len) begin
        res_count   = 2'd1;
        res0.kind   = EV_BODY_DONE;
        phase_next  = PH_DONE;
      end
    end else if (line_end) begin
      res_count = 2'd1;
      if (name_empty) begin
        res0.kind       = EV_HEADERS_DONE;
        phase_next      = PH_BODY;
        body_count_next = '0;
        if (cur_len == '0) begin
          res_count  = 2'd2;
          res0.last  = 1'b0;
          phase_next = PH_DONE;
        end
      end else if (phase == PH_STATUS) begin
        res0.kind  = EV_STATUS_END;
        phase_next = PH_HEADER;
      end else begin
        res0.kind           = EV_HEADER_END;
        res0.content_length = match;
        if (match) begin
          length_found_next = 1'b1;
          length_value_next = value_negative ? '0 : value_acc;
          res0.length       = value_negative ? '0 : value_acc;
        end
      end
      // start of a new line
      prev_was_cr_next        = 1'b0;
      line_first_byte_next    = 1'b1;
      name_empty_next         = 1'b0;
      colon_seen_next         = 1'b0;
      name_match_pos_next     = '0;
      name_still_matches_next = 1'b1;
      value_phase_next        = VP_SKIP;
      value_negative_next     = 1'b0;
      value_acc_next          = '0;
    end else begin
      if (line_first_byte) begin
        name_empty_next      = (data_byte == CH_COLON) || (data_byte == CH_CR);
        line_first_byte_next = 1'b0;
      end else if (name_empty && !colon_seen) begin
        name_empty_next = 1'b0;
      end
      if (!colon_seen) begin
        if (data_byte == CH_COLON) begin
          colon_seen_next = 1'b1;
        end else if (name_still_matches) begin
          if ((name_match_pos < NAME_END) && (data_byte == target_char(name_match_pos))) begin
            name_match_pos_next = name_match_pos + 1'b1;
          end else begin
            name_still_matches_next = 1'b0;
          end
        end
      end else if (value_phase != VP_STOP) begin
        priority if (is_digit) begin
          value_acc_next   = (acc_times_ten > ACC_W'(max_body)) ? max_body
                           : acc_times_ten[LENGTH_BITS-1:0];
          value_phase_next = VP_DIGITS;
        end else if (value_phase == VP_SKIP && is_ws) begin
          value_phase_next = VP_SKIP;
        end else if (value_phase == VP_SKIP &&
                     (data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
          value_negative_next = (data_byte == CH_MINUS);
          value_phase_next    = VP_SIGN;
        end else begin
          value_phase_next = VP_STOP;
        end
      end
      prev_was_cr_next = (data_byte == CH_CR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_STATUS;
      prev_was_cr        <= 1'b0;
      line_first_byte    <= 1'b1;
      name_empty         <= 1'b0;
      colon_seen         <= 1'b0;
      name_match_pos     <= '0;
      name_still_matches <= 1'b1;
      value_phase        <= VP_SKIP;
      value_negative     <= 1'b0;
      value_acc          <= '0;
      length_found       <= 1'b0;
      length_value       <= '0;
      body_count         <= '0;
    end else if (fire) begin
      phase              <= phase_next;
      prev_was_cr        <= prev_was_cr_next;
      line_first_byte    <= line_first_byte_next;
      name_empty         <= name_empty_next;
      colon_seen         <= colon_seen_next;
      name_match_pos     <= name_match_pos_next;
      name_still_matches <= name_still_matches_next;
      value_phase        <= value_phase_next;
      value_negative     <= value_negative_next;
      value_acc          <= value_acc_next;
      length_found       <= length_found_next;
      length_value       <= length_value_next;
      body_count         <= body_count_next;
    end
  end

endmodule

// File: hw/rtl/hhlp_result_fifo.sv
module hhlp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  hhlp_pkg::result_t push0,
  input  hhlp_pkg::result_t push1,
  output logic              room_for_two,
  output logic              out_valid,
  input  logic              out_stall,
  output hhlp_pkg::result_t head
);
  import hhlp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_plus1;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = (count != '0);
  assign room_for_two = (count <= (PTR_W+1)'(DEPTH - 2));
  assign head         = mem[rd_ptr];
  assign wr_ptr_plus1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/hhlp_checker.sv
module hhlp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       event_kind,
  input logic                             is_content_length,
  input logic [hhlp_pkg::LENGTH_BITS-1:0] body_length,
  input logic                             last
);
  import hhlp_pkg::*;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // content-length flag only on a header line end
  a_cl_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_content_length |-> event_kind == EV_HEADER_END)
    else $error("content-length flag on wrong event");

  // headers done followed by body done on the same byte only for empty body
  a_zero_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_HEADERS_DONE && !last |-> body_length == '0)
    else $error("second event after headers with nonzero body");

  // body done is always the final word of its byte
  a_body_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_BODY_DONE |-> last)
    else $error("body done not marked last");

endmodule

bind http_header_length_parser hhlp_checker u_hhlp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .event_kind        (event_kind),
  .is_content_length (is_content_length),
  .body_length       (body_length),
  .last              (last)
);
